// File: rtl/rrpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrpt_pkg;

  typedef enum logic [3:0] {
    CMD_SPAWN    = 4'd0,
    CMD_PAUSE    = 4'd1,
    CMD_SCHEDULE = 4'd2,
    CMD_BLOCK    = 4'd3,
    CMD_WAKE     = 4'd4,
    CMD_KILL     = 4'd5,
    CMD_PICK     = 4'd6,
    CMD_REAP     = 4'd7,
    CMD_SAVE_SP  = 4'd8,
    CMD_READ_SP  = 4'd9,
    CMD_GETPID   = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    SLOT_FREE    = 3'd0,
    SLOT_READY   = 3'd1,
    SLOT_RUNNING = 3'd2,
    SLOT_BLOCKED = 3'd3,
    SLOT_KILLED  = 3'd4
  } slot_state_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_SPAWN,
    FSM_EXEC,
    FSM_PICK,
    FSM_REAP,
    FSM_DONE
  } fsm_e;

  localparam logic [1:0] RS_OK       = 2'd0;
  localparam logic [1:0] RS_NOTFOUND = 2'd1;
  localparam logic [1:0] RS_FULL     = 2'd2;
  localparam logic [1:0] RS_IGNORED  = 2'd3;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] target_pid;
    logic [31:0] operand_value;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_pid;
    logic [31:0] result_value;
    logic        yield_request;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/round_robin_process_table.sv
// block, getpid, kill of pid 0 and unknown commands go from idle straight to done;
// lookup commands walk the ring from slot 0, spawn scans the slots from slot 1 upward,
// pick and reap walk the ring; each visits at most MAX_PROCS slots, spawn at most MAX_PROCS - 1
// one item at a time: a new item is taken only in idle, after the last result entered the output register
// reset: slot 0 holds init pid 0 ready and linked to itself, all others free,
// current slot 0, pid counter 1, quantum 10
`timescale 1ns / 1ps
`default_nettype none
module round_robin_process_table #(
  parameter int MAX_PROCS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  rrpt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output rrpt_pkg::out_item_t  out_item_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [15:0]           cfg_data_i
);

  localparam int IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CntW = $clog2(MAX_PROCS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_PROCS - 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_PROCS - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MAX_PROCS);

  rrpt_pkg::slot_state_e st_q [MAX_PROCS];
  logic [IdxW-1:0] link_q  [MAX_PROCS];
  logic [31:0]     ident_q [MAX_PROCS];
  logic [31:0]     sp_q    [MAX_PROCS];
  logic [31:0]     cpu_q   [MAX_PROCS];
  logic [31:0]     start_q [MAX_PROCS];

  rrpt_pkg::fsm_e      state_q, state_d;
  rrpt_pkg::in_item_t  req_q, req_d;
  rrpt_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [IdxW-1:0]     idx_q, idx_d, prev_q, prev_d, cur_q, cur_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [31:0]         pidc_q, pidc_d;
  logic [15:0]         quantum_q;

  logic                    st_we;
  logic [IdxW-1:0]         st_wa;
  rrpt_pkg::slot_state_e   st_wd;
  logic                    lka_we, lkb_we;
  logic [IdxW-1:0]         lka_wa, lka_wd, lkb_wa, lkb_wd;
  logic                    spawn_we, cpu_we, sp_we;
  logic [31:0]             cpu_wd;

  logic [IdxW-1:0] nxt;
  logic            can_load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rrpt_pkg::FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign nxt         = link_q[idx_q];
  assign can_load    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    n_d         = n_q;
    pidc_d      = pidc_q;
    st_we       = 1'b0;
    st_wa       = idx_q;
    st_wd       = rrpt_pkg::SLOT_READY;
    lka_we      = 1'b0;
    lka_wa      = '0;
    lka_wd      = '0;
    lkb_we      = 1'b0;
    lkb_wa      = '0;
    lkb_wd      = '0;
    spawn_we    = 1'b0;
    cpu_we      = 1'b0;
    sp_we       = 1'b0;
    cpu_wd      = cpu_q[idx_q] + {16'd0, quantum_q};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rrpt_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_item_i;
          res_d   = '0;
          n_d     = '0;
          idx_d   = '0;
          state_d = rrpt_pkg::FSM_DONE;
          case (rrpt_pkg::cmd_e'(in_item_i.command))
            rrpt_pkg::CMD_SPAWN: begin
              idx_d   = IdxW'(1);
              state_d = rrpt_pkg::FSM_SPAWN;
            end
            rrpt_pkg::CMD_PAUSE, rrpt_pkg::CMD_SCHEDULE, rrpt_pkg::CMD_WAKE,
            rrpt_pkg::CMD_SAVE_SP, rrpt_pkg::CMD_READ_SP: begin
              state_d = rrpt_pkg::FSM_LOOKUP;
            end
            rrpt_pkg::CMD_KILL: begin
              if (in_item_i.target_pid == 32'd0) begin
                res_d.status = rrpt_pkg::RS_IGNORED;
              end else begin
                state_d = rrpt_pkg::FSM_LOOKUP;
              end
            end
            rrpt_pkg::CMD_BLOCK: begin
              st_we               = 1'b1;
              st_wa               = cur_q;
              st_wd               = rrpt_pkg::SLOT_BLOCKED;
              res_d.result_pid    = ident_q[cur_q];
              res_d.yield_request = 1'b1;
            end
            rrpt_pkg::CMD_PICK: begin
              res_d.result_pid = ident_q[cur_q];
              idx_d            = cur_q;
              state_d          = rrpt_pkg::FSM_PICK;
            end
            rrpt_pkg::CMD_REAP: begin
              prev_d  = '0;
              idx_d   = link_q[0];
              state_d = rrpt_pkg::FSM_REAP;
            end
            rrpt_pkg::CMD_GETPID: begin
              res_d.result_pid = ident_q[cur_q];
            end
            default: begin
              res_d.status = rrpt_pkg::RS_IGNORED;
            end
          endcase
        end
      end
      rrpt_pkg::FSM_LOOKUP: begin
        if (st_q[idx_q] != rrpt_pkg::SLOT_FREE && ident_q[idx_q] == req_q.target_pid) begin
          state_d = rrpt_pkg::FSM_EXEC;
        end else if (nxt == '0 || n_q == LastCnt) begin
          res_d.status = rrpt_pkg::RS_NOTFOUND;
          state_d      = rrpt_pkg::FSM_DONE;
        end else begin
          idx_d = nxt;
          n_d   = n_q + 1'b1;
        end
      end
      rrpt_pkg::FSM_EXEC: begin
        state_d = rrpt_pkg::FSM_DONE;
        case (rrpt_pkg::cmd_e'(req_q.command))
          rrpt_pkg::CMD_PAUSE: begin
            cpu_we = 1'b1;
            if (st_q[idx_q] == rrpt_pkg::SLOT_RUNNING) begin
              st_we = 1'b1;
            end
          end
          rrpt_pkg::CMD_SCHEDULE: begin
            cur_d = idx_q;
            st_we = 1'b1;
            st_wd = rrpt_pkg::SLOT_RUNNING;
          end
          rrpt_pkg::CMD_WAKE: begin
            st_we = 1'b1;
          end
          rrpt_pkg::CMD_SAVE_SP: begin
            sp_we = 1'b1;
          end
          rrpt_pkg::CMD_READ_SP: begin
            res_d.result_value = sp_q[idx_q];
          end
          rrpt_pkg::CMD_KILL: begin
            res_d.result_value  = req_q.now_ms - start_q[idx_q];
            res_d.yield_request = (idx_q == cur_q);
            st_we               = 1'b1;
            st_wd               = rrpt_pkg::SLOT_KILLED;
          end
          default: begin
          end
        endcase
      end
      rrpt_pkg::FSM_SPAWN: begin
        if (st_q[idx_q] == rrpt_pkg::SLOT_FREE) begin
          spawn_we         = 1'b1;
          cpu_wd           = '0;
          st_we            = 1'b1;
          lka_we           = 1'b1;
          lka_wa           = idx_q;
          lka_wd           = link_q[0];
          lkb_we           = 1'b1;
          lkb_wa           = '0;
          lkb_wd           = idx_q;
          res_d.result_pid = pidc_q;
          pidc_d           = pidc_q + 32'd1;
          state_d          = rrpt_pkg::FSM_DONE;
        end else if (idx_q == LastIdx) begin
          res_d.status = rrpt_pkg::RS_FULL;
          state_d      = rrpt_pkg::FSM_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      rrpt_pkg::FSM_PICK: begin
        if (st_q[nxt] == rrpt_pkg::SLOT_READY) begin
          res_d.result_pid = ident_q[nxt];
          state_d          = rrpt_pkg::FSM_DONE;
        end else if (n_q == LastCnt) begin
          state_d = rrpt_pkg::FSM_DONE;
        end else begin
          idx_d = nxt;
          n_d   = n_q + 1'b1;
        end
      end
      rrpt_pkg::FSM_REAP: begin
        if (idx_q == '0 || n_q == FullCnt) begin
          state_d = rrpt_pkg::FSM_DONE;
        end else begin
          if (st_q[idx_q] == rrpt_pkg::SLOT_KILLED && idx_q != cur_q) begin
            lka_we = 1'b1;
            lka_wa = prev_q;
            lka_wd = nxt;
            lkb_we = 1'b1;
            lkb_wa = idx_q;
            lkb_wd = '0;
            st_we  = 1'b1;
            st_wd  = rrpt_pkg::SLOT_FREE;
          end else begin
            prev_d = idx_q;
          end
          idx_d = nxt;
          n_d   = n_q + 1'b1;
        end
      end
      rrpt_pkg::FSM_DONE: begin
        if (can_load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = rrpt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = rrpt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrpt_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      pidc_q      <= 32'd1;
      quantum_q   <= rrpt_pkg::QUANTUM_RESET;
      idx_q       <= '0;
      prev_q      <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      pidc_q      <= pidc_d;
      idx_q       <= idx_d;
      prev_q      <= prev_d;
      n_q         <= n_d;
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        st_q[i]    <= (i == 0) ? rrpt_pkg::SLOT_READY : rrpt_pkg::SLOT_FREE;
        link_q[i]  <= '0;
        ident_q[i] <= '0;
        sp_q[i]    <= '0;
        cpu_q[i]   <= '0;
        start_q[i] <= '0;
      end
    end else begin
      if (st_we) begin
        st_q[st_wa] <= st_wd;
      end
      if (lka_we) begin
        link_q[lka_wa] <= lka_wd;
      end
      if (lkb_we) begin
        link_q[lkb_wa] <= lkb_wd;
      end
      if (spawn_we) begin
        ident_q[idx_q] <= pidc_q;
        start_q[idx_q] <= req_q.now_ms;
      end
      if (spawn_we || sp_we) begin
        sp_q[idx_q] <= req_q.operand_value;
      end
      if (spawn_we || cpu_we) begin
        cpu_q[idx_q] <= cpu_wd;
      end
    end
  end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int NPROC = 16;
  localparam int CYCLE_LIMIT = 400000;

  class proc_table_scoreboard;
    rrpt_pkg::slot_state_e st[NPROC];
    logic [31:0] ident[NPROC];
    logic [3:0]  link[NPROC];
    logic [31:0] sp[NPROC];
    logic [31:0] cpu[NPROC];
    logic [31:0] start[NPROC];
    logic [3:0]  cur;
    logic [31:0] pid_ctr;
    logic [15:0] quantum;
    rrpt_pkg::out_item_t pending[$];
    int          mismatches;
    int          checked;
    int          live_procs;

    function void clear();
      for (int i = 0; i < NPROC; i++) begin
        st[i] = rrpt_pkg::SLOT_FREE;
        ident[i] = '0;
        link[i] = '0;
        sp[i] = '0;
        cpu[i] = '0;
        start[i] = '0;
      end
      st[0] = rrpt_pkg::SLOT_READY;
      cur = '0;
      pid_ctr = 32'd1;
      quantum = rrpt_pkg::QUANTUM_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function int find_slot(logic [31:0] pid);
      int s;
      s = 0;
      for (int n = 0; n < NPROC; n++) begin
        if (st[s] != rrpt_pkg::SLOT_FREE && ident[s] == pid) return s;
        s = link[s];
        if (s == 0) break;
      end
      return -1;
    endfunction

    function void note_item(rrpt_pkg::in_item_t it);
      rrpt_pkg::out_item_t r;
      int f;
      int s;
      int prev;
      int c;
      int nx;
      r = '0;
      f = -1;
      if (it.command inside {rrpt_pkg::CMD_PAUSE, rrpt_pkg::CMD_SCHEDULE, rrpt_pkg::CMD_WAKE,
                             rrpt_pkg::CMD_SAVE_SP, rrpt_pkg::CMD_READ_SP}) begin
        f = find_slot(it.target_pid);
        if (f < 0) r.status = rrpt_pkg::RS_NOTFOUND;
      end
      case (it.command)
        rrpt_pkg::CMD_SPAWN: begin
          for (s = 1; s < NPROC; s++) if (st[s] == rrpt_pkg::SLOT_FREE) break;
          if (s >= NPROC) begin
            r.status = rrpt_pkg::RS_FULL;
          end else begin
            ident[s] = pid_ctr;
            r.result_pid = pid_ctr;
            pid_ctr = pid_ctr + 1;
            sp[s] = it.operand_value;
            cpu[s] = '0;
            start[s] = it.now_ms;
            st[s] = rrpt_pkg::SLOT_READY;
            link[s] = link[0];
            link[0] = s[3:0];
          end
        end
        rrpt_pkg::CMD_PAUSE: if (f >= 0) begin
          cpu[f] = cpu[f] + quantum;
          if (st[f] == rrpt_pkg::SLOT_RUNNING) st[f] = rrpt_pkg::SLOT_READY;
        end
        rrpt_pkg::CMD_SCHEDULE: if (f >= 0) begin
          cur = f[3:0];
          st[f] = rrpt_pkg::SLOT_RUNNING;
        end
        rrpt_pkg::CMD_BLOCK: begin
          st[cur] = rrpt_pkg::SLOT_BLOCKED;
          r.result_pid = ident[cur];
          r.yield_request = 1'b1;
        end
        rrpt_pkg::CMD_WAKE: if (f >= 0) st[f] = rrpt_pkg::SLOT_READY;
        rrpt_pkg::CMD_KILL: begin
          if (it.target_pid == 0) begin
            r.status = rrpt_pkg::RS_IGNORED;
          end else begin
            f = find_slot(it.target_pid);
            if (f < 0) begin
              r.status = rrpt_pkg::RS_NOTFOUND;
            end else begin
              r.result_value = it.now_ms - start[f];
              st[f] = rrpt_pkg::SLOT_KILLED;
              if (f == cur) r.yield_request = 1'b1;
            end
          end
        end
        rrpt_pkg::CMD_PICK: begin
          r.result_pid = ident[cur];
          s = cur;
          for (int n = 0; n < NPROC; n++) begin
            s = link[s];
            if (st[s] == rrpt_pkg::SLOT_READY) begin
              r.result_pid = ident[s];
              break;
            end
          end
        end
        rrpt_pkg::CMD_REAP: begin
          prev = 0;
          c = link[0];
          for (int n = 0; n < NPROC && c != 0; n++) begin
            nx = link[c];
            if (st[c] == rrpt_pkg::SLOT_KILLED && c != cur) begin
              link[prev] = nx[3:0];
              st[c] = rrpt_pkg::SLOT_FREE;
              link[c] = '0;
            end else begin
              prev = c;
            end
            c = nx;
          end
        end
        rrpt_pkg::CMD_SAVE_SP: if (f >= 0) sp[f] = it.operand_value;
        rrpt_pkg::CMD_READ_SP: if (f >= 0) r.result_value = sp[f];
        rrpt_pkg::CMD_GETPID: r.result_pid = ident[cur];
        default: r.status = rrpt_pkg::RS_IGNORED;
      endcase
      live_procs = 0;
      for (int i = 1; i < NPROC; i++) if (st[i] != rrpt_pkg::SLOT_FREE) live_procs++;
      pending.push_back(r);
    endfunction

    function void check_result(rrpt_pkg::out_item_t got);
      rrpt_pkg::out_item_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status || got.result_pid !== exp_r.result_pid ||
          got.result_value !== exp_r.result_value ||
          got.yield_request !== exp_r.yield_request) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d pid=%h val=%h y=%0d got st=%0d pid=%h val=%h y=%0d",
                   exp_r.status, exp_r.result_pid, exp_r.result_value, exp_r.yield_request,
                   got.status, got.result_pid, got.result_value, got.yield_request);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  rrpt_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  rrpt_pkg::out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  proc_table_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int cycles;
  int sent;

  round_robin_process_table #(.MAX_PROCS(NPROC)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver side: random stall plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic logic [31:0] pick_pid();
    int k;
    k = $urandom_range(9);
    if (k < 7) begin
      k = $urandom_range(NPROC - 1);
      return sb.st[k] != rrpt_pkg::SLOT_FREE ? sb.ident[k] : sb.pid_ctr - 1;
    end
    if (k == 7) return 32'd0;
    if (k == 8) return sb.pid_ctr;
    return $urandom();
  endfunction

  task automatic send_item(rrpt_pkg::in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [3:0] c, logic [31:0] pid, logic [31:0] v, logic [31:0] t);
    rrpt_pkg::in_item_t it;
    it.command = c;
    it.target_pid = pid;
    it.operand_value = v;
    it.now_ms = t;
    send_item(it);
  endtask

  task automatic send_random();
    int k;
    logic [3:0] c;
    k = $urandom_range(99);
    if (k < 2) c = 4'($urandom_range(15, 11));
    else if (k < 15 + (sb.live_procs < 8 ? 12 : 0)) c = rrpt_pkg::CMD_SPAWN;
    else c = 4'($urandom_range(10, 1));
    send_cmd(c, pick_pid(), $urandom(), $urandom());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_quantum(logic [15:0] q);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= q;
    do @(posedge clk); while (!cfg_ready);
    sb.quantum = q;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.live_procs = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    send_cmd(rrpt_pkg::CMD_GETPID, '0, '0, '0);
    send_cmd(rrpt_pkg::CMD_PICK, '0, '0, '0);
    send_cmd(rrpt_pkg::CMD_KILL, 32'd0, '0, 32'd5);
    send_cmd(rrpt_pkg::CMD_SPAWN, '0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_cmd(rrpt_pkg::CMD_SPAWN, '0, 32'h0, 32'd0);
    send_cmd(rrpt_pkg::CMD_READ_SP, 32'd1, '0, '0);
    send_cmd(rrpt_pkg::CMD_SAVE_SP, 32'd2, 32'hA5A5_5A5A, '0);
    send_cmd(rrpt_pkg::CMD_READ_SP, 32'd2, '0, '0);
    send_cmd(rrpt_pkg::CMD_SCHEDULE, 32'd1, '0, '0);
    send_cmd(rrpt_pkg::CMD_PAUSE, 32'd1, '0, '0);
    send_cmd(rrpt_pkg::CMD_SCHEDULE, 32'd2, '0, '0);
    send_cmd(rrpt_pkg::CMD_BLOCK, '0, '0, '0);
    send_cmd(rrpt_pkg::CMD_WAKE, 32'd2, '0, '0);
    send_cmd(rrpt_pkg::CMD_PAUSE, 32'hFFFF_FFFF, '0, '0);
    send_cmd(rrpt_pkg::CMD_KILL, 32'd1, '0, 32'd3);
    send_cmd(rrpt_pkg::CMD_KILL, 32'd2, '0, 32'd9);
    send_cmd(rrpt_pkg::CMD_REAP, '0, '0, '0);
    send_cmd(rrpt_pkg::CMD_WAKE, 32'd2, '0, '0);
    send_cmd(rrpt_pkg::CMD_PICK, '0, '0, '0);
    send_cmd(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) send_cmd(rrpt_pkg::CMD_SPAWN, '0, $urandom(), $urandom());
    send_cmd(rrpt_pkg::CMD_KILL, 32'hDEAD_BEEF, '0, '0);
    write_quantum(16'hFFFF);
    send_cmd(rrpt_pkg::CMD_PAUSE, 32'd3, '0, '0);
    write_quantum(16'h0000);
    send_cmd(rrpt_pkg::CMD_PAUSE, 32'd3, '0, '0);

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1 ? 47 : 0);
      recv_idle_pct = (ph == 0) ? 47 : (ph == 1 ? 15 : 0);
      write_quantum(ph == 2 ? rrpt_pkg::QUANTUM_RESET : 16'($urandom()));
      if (ph == 1) hold_cycles = 300;
      for (int i = 0; i < 370; i++) begin
        send_random();
        if (i == 200) drain();
      end
    end

    drain();
    $display("sent %0d commands, checked %0d results over three idle mixes", sent, sb.checked);
    $display("quantum extremes, full table, reaps and unknown pids exercised");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/rrpt_pkg.sv
rtl/round_robin_process_table.sv
sim/tb_top.sv
